[rtl/ccd_pkg.sv]
// ccd_pkg: shared types, constants and helper functions for the clock and
// calendar display unit. No dependencies.
`timescale 1ns / 1ps

package ccd_pkg;

  // Counter limits
  localparam int unsigned TenthsPerSec  = 10;
  localparam int unsigned SecsPerMin    = 60;
  localparam int unsigned MinsPerHour   = 60;
  localparam int unsigned HoursPerDay   = 24;
  localparam int unsigned DaysShortFeb  = 28;
  localparam int unsigned DaysShortMon  = 30;
  localparam int unsigned DaysLongMon   = 31;
  localparam int unsigned MonthsPerYear = 12;
  localparam int unsigned YearsPerCent  = 100;
  localparam int unsigned HoursHalfDay  = 12;

  // Reset values of the calendar
  localparam logic [4:0]  DayReset   = 5'd1;
  localparam logic [3:0]  MonthReset = 4'd1;
  localparam logic [13:0] YearReset  = 14'd2000;
  // 2000 mod 100 and (2000 / 100) mod 4
  localparam logic [6:0]  YearMod100Reset = 7'd0;
  localparam logic [1:0]  CentMod4Reset   = 2'd0;

  // Month codes with special lengths
  localparam logic [3:0] MonthFeb = 4'd2;
  localparam logic [3:0] MonthApr = 4'd4;
  localparam logic [3:0] MonthJun = 4'd6;
  localparam logic [3:0] MonthSep = 4'd9;
  localparam logic [3:0] MonthNov = 4'd11;

  // Character codes
  localparam logic [5:0] CharZero  = 6'd48;
  localparam logic [6:0] CharA     = 7'd65;
  localparam logic [6:0] CharP     = 7'd80;
  localparam logic [6:0] CharM     = 7'd77;
  localparam logic [6:0] CharSpace = 7'd32;

  // Configuration register indexes
  localparam logic RegTwelveHour = 1'b0;

  // One result item
  typedef struct packed {
    logic [5:0]  hour_tens_char;
    logic [5:0]  hour_ones_char;
    logic [5:0]  minute_tens_char;
    logic [5:0]  minute_ones_char;
    logic [5:0]  second_tens_char;
    logic [5:0]  second_ones_char;
    logic [6:0]  meridiem_char;
    logic [6:0]  meridiem_m_char;
    logic [4:0]  day_of_month;
    logic [3:0]  month_number;
    logic [13:0] year_number;
  } ccd_result_t;

  // Tens digit of a value below 64, by compare chain
  function automatic logic [2:0] tens_digit(input logic [5:0] v);
    logic [2:0] t;
    if (v >= 6'd60)      t = 3'd6;
    else if (v >= 6'd50) t = 3'd5;
    else if (v >= 6'd40) t = 3'd4;
    else if (v >= 6'd30) t = 3'd3;
    else if (v >= 6'd20) t = 3'd2;
    else if (v >= 6'd10) t = 3'd1;
    else                 t = 3'd0;
    return t;
  endfunction

  // Tens and ones ASCII characters of a value below 64, packed {tens, ones}
  function automatic logic [11:0] to_chars(input logic [5:0] v);
    logic [2:0] t;
    logic [5:0] tens10;
    logic [5:0] ones;
    t      = tens_digit(v);
    tens10 = {t, 3'b000} + {2'b00, t, 1'b0};
    ones   = v - tens10;
    return {CharZero + {3'b000, t}, CharZero + ones};
  endfunction

endpackage

[rtl/ccd_if.sv]
// ccd_if: valid/ready stream interfaces for the refresh input and the
// display result output. Depends on ccd_pkg.
`timescale 1ns / 1ps

interface ccd_in_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

interface ccd_out_if;
  import ccd_pkg::*;
  logic        valid;
  logic        ready;
  logic [5:0]  hour_tens_char;
  logic [5:0]  hour_ones_char;
  logic [5:0]  minute_tens_char;
  logic [5:0]  minute_ones_char;
  logic [5:0]  second_tens_char;
  logic [5:0]  second_ones_char;
  logic [6:0]  meridiem_char;
  logic [6:0]  meridiem_m_char;
  logic [4:0]  day_of_month;
  logic [3:0]  month_number;
  logic [13:0] year_number;

  modport source (
    output valid, input ready,
    output hour_tens_char, hour_ones_char, minute_tens_char, minute_ones_char,
    output second_tens_char, second_ones_char, meridiem_char, meridiem_m_char,
    output day_of_month, month_number, year_number
  );
  modport sink (
    input valid, output ready,
    input hour_tens_char, hour_ones_char, minute_tens_char, minute_ones_char,
    input second_tens_char, second_ones_char, meridiem_char, meridiem_m_char,
    input day_of_month, month_number, year_number
  );
endinterface

[rtl/clock_calendar_display_unit.sv]
// clock_calendar_display_unit: tick-driven clock with Gregorian calendar and
// ASCII time display. Depends on ccd_pkg and the ccd_in_if / ccd_out_if interfaces.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+------------------------------------
//   in_i    | in  | valid/ready        | tick
//   out_o   | out | valid/ready        | time chars, meridiem, day/month/year
//   apb     | in  | psel/penable/pready| twelve_hour_mode at byte address 0
//
// Each transfer in gives one result in the cycle after, held in an output register.
// A new item is taken every cycle while the output register is empty or being
// drained, so the sustained rate is one item per cycle.
// Reset (asynchronous, active low) sets 00:00:00.0, 1 January 2000, 24-hour mode.
// A stall on out_o holds the result and blocks in_i only while it persists.
`timescale 1ns / 1ps

module clock_calendar_display_unit
  import ccd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o,
  ccd_in_if.sink      in_i,
  ccd_out_if.source   out_o
);

  // Configuration register
  logic mode_q;
  logic cfg_wr;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && (paddr_i[2] == RegTwelveHour);
  assign prdata_o = (paddr_i[2] == RegTwelveHour) ? {31'd0, mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_wr) begin
      mode_q <= pwdata_i[0];
    end
  end

  // Clock and calendar state; year residues track the leap-year rule
  logic [3:0]  tenths_q, tenths_d;
  logic [5:0]  secs_q, secs_d;
  logic [5:0]  mins_q, mins_d;
  logic [4:0]  hours_q, hours_d;
  logic [4:0]  day_q, day_d;
  logic [3:0]  month_q, month_d;
  logic [13:0] year_q, year_d;
  logic [6:0]  ymod100_q, ymod100_d;
  logic [1:0]  cent4_q, cent4_d;

  // Output register
  logic        out_valid_q;
  ccd_result_t res_q, res_d;

  logic in_xfer;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_xfer    = in_i.valid && in_i.ready;

  // Next-state cascade for one item
  logic sec_step, min_step, hour_step, day_step, leap, month_end, year_step;

  always_comb begin
    tenths_d  = tenths_q;
    secs_d    = secs_q;
    mins_d    = mins_q;
    hours_d   = hours_q;
    day_d     = day_q;
    month_d   = month_q;
    year_d    = year_q;
    ymod100_d = ymod100_q;
    cent4_d   = cent4_q;

    leap = (year_q[1:0] == 2'd0) && ((ymod100_q != 7'd0) || (cent4_q == 2'd0));

    sec_step  = in_i.tick && (tenths_q >= 4'(TenthsPerSec - 1));
    min_step  = sec_step && (secs_q >= 6'(SecsPerMin - 1));
    hour_step = min_step && (mins_q >= 6'(MinsPerHour - 1));
    day_step  = hour_step && (hours_q >= 5'(HoursPerDay - 1));

    // Last day of the current month
    if (day_q < 5'(DaysShortFeb)) begin
      month_end = 1'b0;
    end else if (month_q == MonthFeb) begin
      month_end = !((day_q == 5'(DaysShortFeb)) && leap);
    end else if ((month_q == MonthApr) || (month_q == MonthJun) ||
                 (month_q == MonthSep) || (month_q == MonthNov)) begin
      month_end = (day_q >= 5'(DaysShortMon));
    end else begin
      month_end = (day_q >= 5'(DaysLongMon));
    end
    year_step = day_step && month_end && (month_q >= 4'(MonthsPerYear));

    if (in_i.tick) begin
      tenths_d = sec_step ? 4'd0 : tenths_q + 4'd1;
    end
    if (sec_step) begin
      secs_d = min_step ? 6'd0 : secs_q + 6'd1;
    end
    if (min_step) begin
      mins_d = hour_step ? 6'd0 : mins_q + 6'd1;
    end
    if (hour_step) begin
      hours_d = day_step ? 5'd0 : hours_q + 5'd1;
    end
    if (day_step) begin
      if (month_end) begin
        day_d   = DayReset;
        month_d = year_step ? MonthReset : month_q + 4'd1;
      end else begin
        day_d = day_q + 5'd1;
      end
    end

    // Year advance; the wrap to year 0 restarts both residues
    if (year_step) begin
      year_d = year_q + 14'd1;
      if (year_q == 14'h3FFF) begin
        ymod100_d = 7'd0;
        cent4_d   = 2'd0;
      end else if (ymod100_q >= 7'(YearsPerCent - 1)) begin
        ymod100_d = 7'd0;
        cent4_d   = cent4_q + 2'd1;
      end else begin
        ymod100_d = ymod100_q + 7'd1;
      end
    end
  end

  // Result from the updated state
  logic [4:0]  shown_hour;
  logic [11:0] hour_chars, min_chars, sec_chars;

  always_comb begin
    if (hours_d == 5'd0) begin
      shown_hour = 5'(HoursHalfDay);
    end else if (mode_q && (hours_d > 5'(HoursHalfDay))) begin
      shown_hour = hours_d - 5'(HoursHalfDay);
    end else begin
      shown_hour = hours_d;
    end
    hour_chars = to_chars({1'b0, shown_hour});
    min_chars  = to_chars(mins_d);
    sec_chars  = to_chars(secs_d);

    res_d.hour_tens_char   = hour_chars[11:6];
    res_d.hour_ones_char   = hour_chars[5:0];
    res_d.minute_tens_char = min_chars[11:6];
    res_d.minute_ones_char = min_chars[5:0];
    res_d.second_tens_char = sec_chars[11:6];
    res_d.second_ones_char = sec_chars[5:0];
    if (mode_q) begin
      res_d.meridiem_char   = (hours_d <= 5'(HoursHalfDay - 1)) ? CharA : CharP;
      res_d.meridiem_m_char = CharM;
    end else begin
      res_d.meridiem_char   = CharSpace;
      res_d.meridiem_m_char = CharSpace;
    end
    res_d.day_of_month = day_d;
    res_d.month_number = month_d;
    res_d.year_number  = year_d;
  end

  // State registers, updated on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tenths_q  <= 4'd0;
      secs_q    <= 6'd0;
      mins_q    <= 6'd0;
      hours_q   <= 5'd0;
      day_q     <= DayReset;
      month_q   <= MonthReset;
      year_q    <= YearReset;
      ymod100_q <= YearMod100Reset;
      cent4_q   <= CentMod4Reset;
    end else if (in_xfer) begin
      tenths_q  <= tenths_d;
      secs_q    <= secs_d;
      mins_q    <= mins_d;
      hours_q   <= hours_d;
      day_q     <= day_d;
      month_q   <= month_d;
      year_q    <= year_d;
      ymod100_q <= ymod100_d;
      cent4_q   <= cent4_d;
    end
  end

  // Output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.hour_tens_char   = res_q.hour_tens_char;
  assign out_o.hour_ones_char   = res_q.hour_ones_char;
  assign out_o.minute_tens_char = res_q.minute_tens_char;
  assign out_o.minute_ones_char = res_q.minute_ones_char;
  assign out_o.second_tens_char = res_q.second_tens_char;
  assign out_o.second_ones_char = res_q.second_ones_char;
  assign out_o.meridiem_char    = res_q.meridiem_char;
  assign out_o.meridiem_m_char  = res_q.meridiem_m_char;
  assign out_o.day_of_month     = res_q.day_of_month;
  assign out_o.month_number     = res_q.month_number;
  assign out_o.year_number      = res_q.year_number;

  // Assertions
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_q)
    else $error("no result after input transfer");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tenths_q < 4'(TenthsPerSec)) && (secs_q < 6'(SecsPerMin)) &&
    (mins_q < 6'(MinsPerHour)) && (hours_q < 5'(HoursPerDay)))
    else $error("time counter out of range");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (day_q != 5'd0) && (month_q != 4'd0) && (month_q <= 4'(MonthsPerYear)))
    else $error("date counter out of range");

  a_year_residue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ymod100_q < 7'(YearsPerCent)) && (ymod100_q[1:0] == year_q[1:0]))
    else $error("year residue out of step with year");

endmodule

[verif/tb_clock_calendar_display_unit.sv]
// tb_clock_calendar_display_unit: self-checking bench for the clock and calendar
// display unit. Random refresh and tick traffic with bursty stalls on both sides.
// Depends on ccd_pkg, ccd_in_if / ccd_out_if and clock_calendar_display_unit.
`timescale 1ns / 1ps

module tb_clock_calendar_display_unit;
  import ccd_pkg::*;

  localparam logic [2:0] TwelveHourAddr = {RegTwelveHour, 2'b00};
  // No register lives here; writes must be dropped
  localparam logic [2:0] UnusedRegAddr  = 3'd4;
  localparam int         BacklogAt      = 150;
  localparam int         BacklogCycles  = 64;
  localparam int         TimeoutNs      = 2_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        psel_i;
  logic        penable_i;
  logic        pwrite_i;
  logic [2:0]  paddr_i;
  logic [31:0] pwdata_i;
  logic [31:0] prdata_o;
  logic        pready_o;

  ccd_in_if  in_ch ();
  ccd_out_if out_ch ();

  clock_calendar_display_unit dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel_i),
    .penable_i (penable_i),
    .pwrite_i  (pwrite_i),
    .paddr_i   (paddr_i),
    .pwdata_i  (pwdata_i),
    .prdata_o  (prdata_o),
    .pready_o  (pready_o),
    .in_i      (in_ch),
    .out_o     (out_ch)
  );

  // Local copy of the clock, calendar and display mode
  logic        hour12_mode = 1'b0;
  logic [3:0]  tenths_cnt  = '0;
  logic [5:0]  secs_cnt    = '0;
  logic [5:0]  mins_cnt    = '0;
  logic [4:0]  hrs_cnt     = '0;
  logic [4:0]  day_cnt     = DayReset;
  logic [3:0]  month_cnt   = MonthReset;
  logic [13:0] year_cnt    = YearReset;

  logic        pending_ticks_q[$];
  ccd_result_t expected_display_q[$];

  int fail_cnt     = 0;
  int sent_cnt     = 0;
  int send_gap     = 0;
  int stall_left   = 0;
  bit no_idle      = 1'b0;
  bit backlog_hold = 1'b0;
  bit backlog_done = 1'b0;

  // Count one refresh (and tick, if set), then format the display
  function automatic ccd_result_t tick_and_display(input logic tick);
    ccd_result_t r;
    int unsigned shown;
    bit          leap;
    if (tick) begin
      tenths_cnt = tenths_cnt + 4'd1;
      if (tenths_cnt >= TenthsPerSec) begin
        tenths_cnt = '0;
        if (secs_cnt + 1 >= SecsPerMin) begin
          secs_cnt = '0;
          if (mins_cnt + 1 >= MinsPerHour) begin
            mins_cnt = '0;
            if (hrs_cnt + 1 >= HoursPerDay) begin
              hrs_cnt = '0;
              // Midnight: advance the Gregorian calendar
              leap = (year_cnt % (4 * YearsPerCent) == 0) ||
                     ((year_cnt % YearsPerCent != 0) && (year_cnt % 4 == 0));
              if (day_cnt < DaysShortFeb) begin
                day_cnt++;
              end else if (month_cnt == MonthFeb) begin
                if (day_cnt == DaysShortFeb && leap) begin
                  day_cnt++;
                end else begin
                  month_cnt++;
                  day_cnt = DayReset;
                end
              end else if (month_cnt == MonthApr || month_cnt == MonthJun ||
                           month_cnt == MonthSep || month_cnt == MonthNov) begin
                if (day_cnt < DaysShortMon) begin
                  day_cnt++;
                end else begin
                  month_cnt++;
                  day_cnt = DayReset;
                end
              end else if (day_cnt < DaysLongMon) begin
                day_cnt++;
              end else begin
                if (month_cnt >= MonthsPerYear) begin
                  year_cnt++;  // wraps at 14 bits
                  month_cnt = MonthReset;
                end else begin
                  month_cnt++;
                end
                day_cnt = DayReset;
              end
            end else begin
              hrs_cnt++;
            end
          end else begin
            mins_cnt++;
          end
        end else begin
          secs_cnt++;
        end
      end
    end

    // Midnight hour reads 12 in both modes
    if (hrs_cnt == 0)
      shown = HoursHalfDay;
    else if (hour12_mode && hrs_cnt > HoursHalfDay)
      shown = hrs_cnt - HoursHalfDay;
    else
      shown = hrs_cnt;

    r.hour_tens_char   = 6'(CharZero + (shown / 10) % 10);
    r.hour_ones_char   = 6'(CharZero + shown % 10);
    r.minute_tens_char = 6'(CharZero + (mins_cnt / 10) % 10);
    r.minute_ones_char = 6'(CharZero + mins_cnt % 10);
    r.second_tens_char = 6'(CharZero + (secs_cnt / 10) % 10);
    r.second_ones_char = 6'(CharZero + secs_cnt % 10);
    r.meridiem_char    = hour12_mode ? ((hrs_cnt < HoursHalfDay) ? CharA : CharP)
                                     : CharSpace;
    r.meridiem_m_char  = hour12_mode ? CharM : CharSpace;
    r.day_of_month     = day_cnt;
    r.month_number     = month_cnt;
    r.year_number      = year_cnt;
    return r;
  endfunction

  task automatic check_field(input string label, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      fail_cnt++;
    end
  endtask

  // APB write: setup then access phase, done once pready is seen
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= addr;
    pwdata_i  <= data;
    @(posedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
    if (addr == TwelveHourAddr)
      hour12_mode = data[0];
  endtask

  task automatic queue_refreshes(input int count, input int tick_pct);
    repeat (count)
      pending_ticks_q.push_back($urandom_range(0, 99) < tick_pct);
  endtask

  // Block is idle once nothing is queued, offered or outstanding
  task automatic wait_drained();
    while (pending_ticks_q.size() != 0 || in_ch.valid || expected_display_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Refresh driver: holds an offer until its transfer, then idles or sends the next
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_display_q.push_back(tick_and_display(in_ch.tick));
        pending_ticks_q.delete(0);
        sent_cnt++;
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (send_gap != 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_ticks_q.size() == 0) begin
          in_ch.valid <= 1'b0;
        end else if (!no_idle && !backlog_hold && $urandom_range(0, 5) == 0) begin
          send_gap = $urandom_range(0, 5);
          in_ch.valid <= 1'b0;
        end else begin
          in_ch.valid <= 1'b1;
          in_ch.tick  <= pending_ticks_q[0];
        end
      end
    end
  end

  // Display monitor: checks each transfer, stalls in bursts, one long backlog hold
  always @(posedge clk_i) begin : display_monitor
    ccd_result_t want;
    logic        next_ready;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_display_q.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual %0d-%0d-%0d",
                   $time, out_ch.year_number, out_ch.month_number, out_ch.day_of_month);
          fail_cnt++;
        end else begin
          want = expected_display_q.pop_front();
          check_field("hour_tens_char", want.hour_tens_char, out_ch.hour_tens_char);
          check_field("hour_ones_char", want.hour_ones_char, out_ch.hour_ones_char);
          check_field("minute_tens_char", want.minute_tens_char, out_ch.minute_tens_char);
          check_field("minute_ones_char", want.minute_ones_char, out_ch.minute_ones_char);
          check_field("second_tens_char", want.second_tens_char, out_ch.second_tens_char);
          check_field("second_ones_char", want.second_ones_char, out_ch.second_ones_char);
          check_field("meridiem_char", want.meridiem_char, out_ch.meridiem_char);
          check_field("meridiem_m_char", want.meridiem_m_char, out_ch.meridiem_m_char);
          check_field("day_of_month", want.day_of_month, out_ch.day_of_month);
          check_field("month_number", want.month_number, out_ch.month_number);
          check_field("year_number", want.year_number, out_ch.year_number);
        end
      end

      if (stall_left != 0) begin
        stall_left--;
        next_ready = 1'b0;
      end else if (!backlog_done && sent_cnt >= BacklogAt) begin
        // Long hold so the input side backs up while the driver keeps offering
        backlog_done = 1'b1;
        backlog_hold = 1'b1;
        stall_left   = BacklogCycles - 1;
        next_ready   = 1'b0;
      end else begin
        backlog_hold = 1'b0;
        if (!no_idle && $urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(0, 5);
          next_ready = 1'b0;
        end else begin
          next_ready = 1'b1;
        end
      end
      out_ch.ready <= next_ready;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    psel_i       = 1'b0;
    penable_i    = 1'b0;
    pwrite_i     = 1'b0;
    paddr_i      = '0;
    pwdata_i     = '0;
    in_ch.valid  = 1'b0;
    in_ch.tick   = 1'b0;
    out_ch.ready = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 24-hour display at midnight, refresh-only and tick items
    write_reg(TwelveHourAddr, 32'd0);
    pending_ticks_q.push_back(1'b0);
    repeat (3) pending_ticks_q.push_back(1'b1);
    pending_ticks_q.push_back(1'b0);
    wait_drained();

    // 12-hour mode with upper data bits set; a write to no register is dropped
    write_reg(TwelveHourAddr, 32'hFFFF_FFFF);
    write_reg(UnusedRegAddr, 32'd0);
    pending_ticks_q.push_back(1'b0);
    repeat (12) pending_ticks_q.push_back(1'b1);  // carries into the seconds
    pending_ticks_q.push_back(1'b0);
    wait_drained();

    // Random phases across display modes
    write_reg(TwelveHourAddr, {31'($urandom()), 1'b0});
    queue_refreshes(400, 85);
    wait_drained();

    write_reg(TwelveHourAddr, 32'd1);
    queue_refreshes(400, 90);
    wait_drained();

    write_reg(TwelveHourAddr, 32'd0);
    queue_refreshes(300, 50);
    wait_drained();

    // Back-to-back tail with no stalls on either side; drop any stall in progress
    write_reg(TwelveHourAddr, {31'($urandom()), 1'b1});
    no_idle    = 1'b1;
    stall_left = 0;
    queue_refreshes(200, 90);
    wait_drained();

    if (fail_cnt == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #(TimeoutNs);
    $display("Regression FAIL");
    $finish;
  end

endmodule

[clock_calendar_display_unit.f]
rtl/ccd_pkg.sv
rtl/ccd_if.sv
rtl/clock_calendar_display_unit.sv
verif/tb_clock_calendar_display_unit.sv
